FILE: src/sspg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types, constants and helpers for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package sspg_pkg;

  // Width of the remaining-toggle counter (two's complement, negative = run forever).
  localparam int COUNT_WIDTH = 16;

  localparam int HALF_PERIOD_WIDTH = 16;
  localparam int RELOAD_WIDTH      = 15;
  localparam int TOGGLE_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int CFG_DATA_WIDTH    = 16;

  localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd624;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HALF_PERIOD  = 2'd0,
    REG_BOUNCE_MODE  = 2'd1,
    REG_RELOAD_COUNT = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic                           move_dir;
    logic signed [TOGGLE_WIDTH-1:0] toggle_count;
  } cmd_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic moving;
    logic move_done;
  } rsp_t;

  typedef struct packed {
    logic [HALF_PERIOD_WIDTH-1:0] half_period;
    logic                         bounce_mode;
    logic [RELOAD_WIDTH-1:0]      reload_count;
  } cfg_t;

  // Sign-extend (or truncate) a move count to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] count_from_toggle(
      input logic signed [TOGGLE_WIDTH-1:0] value);
    logic signed [31:0] ext;
    ext = 32'(value);
    return ext[COUNT_WIDTH-1:0];
  endfunction

  // Zero-extend (or truncate) the reload value to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] count_from_reload(
      input logic [RELOAD_WIDTH-1:0] value);
    logic [31:0] ext;
    ext = 32'(value);
    return ext[COUNT_WIDTH-1:0];
  endfunction

endpackage

FILE: src/stepper_step_pulse_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_unit
// Step/direction pulse generator for one stepper axis.
// ----------------------------------------------------------------------------
// Each command transaction is a timer tick, a start move or a stop; every
// accepted command produces exactly one response transaction carrying the
// step and direction line levels, the moving flag and a move-done flag.
// Commands are taken one per clock while the response side keeps up: the axis
// state (tick counter, remaining toggles, direction, step line, running flag)
// updates on the accept edge through one short pass of compare/decrement
// logic, and the response lands in an output register. A new command is
// accepted whenever that register is empty or is being drained in the same
// cycle, so sustained throughput is one transaction per cycle. Configuration
// writes (half_period, bounce_mode, reload_count) are always accepted;
// cfg_ready is tied high. Write them only while the axis is idle.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_unit
  import sspg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cmd_t                       cmd,
  // response channel
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output rsp_t                       rsp,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  sspg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Axis state
  logic [HALF_PERIOD_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0]       remaining, remaining_next;
  logic                         dir_reg, dir_reg_next;
  logic                         step_reg, step_reg_next;
  logic                         running, running_next;
  logic                         done;

  logic                         accept;
  logic [HALF_PERIOD_WIDTH-1:0] period;
  logic [HALF_PERIOD_WIDTH-1:0] tick_inc;

  // Output register frees up on the same edge it drains.
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  // A zero half period behaves as one: an event on every tick.
  assign period   = (cfg.half_period == '0) ? HALF_PERIOD_WIDTH'(1) : cfg.half_period;
  assign tick_inc = tick_count + HALF_PERIOD_WIDTH'(1);

  always_comb begin
    tick_count_next = tick_count;
    remaining_next  = remaining;
    dir_reg_next    = dir_reg;
    step_reg_next   = step_reg;
    running_next    = running;
    done            = 1'b0;

    case (opcode_t'(cmd.opcode))
      OP_TICK: begin
        if (running) begin
          tick_count_next = tick_inc;
          if (tick_inc >= period) begin
            // compare event
            tick_count_next = '0;
            step_reg_next   = !step_reg;
            if (remaining == '0) begin
              if (cfg.bounce_mode && (cfg.reload_count != '0)) begin
                dir_reg_next   = !dir_reg;
                remaining_next = count_from_reload(cfg.reload_count);
              end else begin
                step_reg_next = 1'b0;
                running_next  = 1'b0;
                done          = 1'b1;
              end
            end else if (!remaining[COUNT_WIDTH-1]) begin
              remaining_next = remaining - COUNT_WIDTH'(1);
            end
            // negative count: run forever, no decrement
          end
        end
      end
      OP_START: begin
        if (cmd.toggle_count == '0) begin
          // zero count acts as a stop; dir and remaining untouched
          step_reg_next   = 1'b0;
          running_next    = 1'b0;
          tick_count_next = '0;
        end else begin
          dir_reg_next    = cmd.move_dir;
          remaining_next  = count_from_toggle(cmd.toggle_count);
          running_next    = 1'b1;
          tick_count_next = '0;
        end
      end
      OP_STOP: begin
        step_reg_next   = 1'b0;
        running_next    = 1'b0;
        tick_count_next = '0;
      end
      default: ;  // unused opcode: report current state
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      remaining  <= '1;
      dir_reg    <= 1'b0;
      step_reg   <= 1'b0;
      running    <= 1'b0;
    end else if (accept) begin
      tick_count <= tick_count_next;
      remaining  <= remaining_next;
      dir_reg    <= dir_reg_next;
      step_reg   <= step_reg_next;
      running    <= running_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.step_level <= step_reg_next;
      rsp.dir_level  <= dir_reg_next;
      rsp.moving     <= running_next;
      rsp.move_done  <= done;
    end
  end

endmodule

FILE: src/sspg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspg_cfg_regs
// Configuration register file: half period, bounce mode, reload count.
// ----------------------------------------------------------------------------
module sspg_cfg_regs
  import sspg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period  <= HALF_PERIOD_RESET;
      cfg.bounce_mode  <= 1'b0;
      cfg.reload_count <= '0;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        REG_HALF_PERIOD:  cfg.half_period  <= wr_data[HALF_PERIOD_WIDTH-1:0];
        REG_BOUNCE_MODE:  cfg.bounce_mode  <= wr_data[0];
        REG_RELOAD_COUNT: cfg.reload_count <= wr_data[RELOAD_WIDTH-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_stepper_step_pulse_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_step_pulse_generator_unit
// Self-checking testbench for the step/direction pulse generator.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own copy of the axis state and the three
// configuration registers. It advances that copy on every accepted command
// and queues the step/dir/moving/done levels the block has to answer with.
// Responses are compared field by field in arrival order. The run starts
// with a short directed sequence, then walks through several register
// settings (extremes included) with random command streams. Commands go
// out in bursts with random gaps, and the response side stalls on its own
// duty-cycle pattern.
// ----------------------------------------------------------------------------
module tb_stepper_step_pulse_generator_unit;
  import sspg_pkg::*;

  // Pipeline depth is one register; spare settle cycles catch stray responses.
  localparam int SETTLE_CYCLES  = 4;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 120;

  // --------------------------------------------------------------------------
  // Scoreboard: axis predictor plus queue of expected output levels
  // --------------------------------------------------------------------------
  class axis_scoreboard;
    // configuration registers
    logic [HALF_PERIOD_WIDTH-1:0] half_period;
    logic                         bounce_mode;
    logic [RELOAD_WIDTH-1:0]      reload_count;
    // axis state
    logic [15:0]                  tick_count;
    logic [COUNT_WIDTH-1:0]       remaining;
    logic                         dir_reg;
    logic                         step_reg;
    logic                         running;

    rsp_t expected_levels[$];
    int   mismatches;
    int   responses;
    int   step_events;
    int   moves_done;

    function new();
      half_period  = HALF_PERIOD_RESET;
      bounce_mode  = 1'b0;
      reload_count = '0;
      tick_count   = '0;
      remaining    = '1;
      dir_reg      = 1'b0;
      step_reg     = 1'b0;
      running      = 1'b0;
      mismatches   = 0;
      responses    = 0;
      step_events  = 0;
      moves_done   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_HALF_PERIOD:  half_period  = data[HALF_PERIOD_WIDTH-1:0];
        REG_BOUNCE_MODE:  bounce_mode  = data[0];
        REG_RELOAD_COUNT: reload_count = data[RELOAD_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void halt_axis();
      step_reg   = 1'b0;
      running    = 1'b0;
      tick_count = '0;
    endfunction

    // Advance the axis by one command; returns 1 when the command did work.
    function bit apply_command(cmd_t c);
      rsp_t               levels;
      logic [15:0]        period;
      logic signed [31:0] wide;
      bit                 active;
      levels = '0;
      active = 1'b1;
      case (c.opcode)
        OP_TICK: begin
          active = running;
          if (running) begin
            // zero period behaves as one: an event on every tick
            period = (half_period == '0) ? 16'd1 : 16'(half_period);
            tick_count = tick_count + 16'd1;
            if (tick_count >= period) begin
              tick_count = '0;
              step_reg = ~step_reg;
              step_events++;
              if (remaining == '0) begin
                if (bounce_mode && reload_count != '0) begin
                  dir_reg   = ~dir_reg;
                  remaining = COUNT_WIDTH'(reload_count);
                end else begin
                  halt_axis();
                  levels.move_done = 1'b1;
                  moves_done++;
                end
              end else if (!remaining[COUNT_WIDTH-1]) begin
                remaining = remaining - 1'b1;
              end
              // negative count: run forever, no decrement
            end
          end
        end
        OP_START: begin
          if (c.toggle_count == '0) begin
            halt_axis();
          end else begin
            wide       = c.toggle_count;
            dir_reg    = c.move_dir;
            remaining  = wide[COUNT_WIDTH-1:0];
            running    = 1'b1;
            tick_count = '0;
          end
        end
        OP_STOP: halt_axis();
        default: active = 1'b0;
      endcase
      levels.step_level = step_reg;
      levels.dir_level  = dir_reg;
      levels.moving     = running;
      expected_levels.push_back(levels);
      return active;
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, actual %0b", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_levels(rsp_t got);
      rsp_t want;
      if (expected_levels.size() == 0) begin
        $error("response with nothing outstanding: %b", got);
        mismatches++;
        return;
      end
      want = expected_levels.pop_front();
      responses++;
      compare_bit("step_level", want.step_level, got.step_level);
      compare_bit("dir_level",  want.dir_level,  got.dir_level);
      compare_bit("moving",     want.moving,     got.moving);
      compare_bit("move_done",  want.move_done,  got.move_done);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  cmd_t                       cmd = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  rsp_t                       rsp;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  stepper_step_pulse_generator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  axis_scoreboard sb;

  int burst_left     = 0;
  int commands_sent  = 0;
  int active_items   = 0;
  int reg_writes     = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Response side: ready follows a duty-cycle pattern that is re-picked when
  // its random run length expires; a zero stall length gives stretches of full throughput.
  // --------------------------------------------------------------------------
  int unsigned stall_period  = 2;
  int unsigned stall_len     = 0;
  int unsigned stall_phase   = 0;
  int unsigned pattern_left  = 0;

  always @(posedge clk) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(40, 160);
      stall_period = $urandom_range(2, 8);
      stall_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
    end
    pattern_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    rsp_ready <= (stall_phase >= stall_len);
  end

  // Every response transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_levels(rsp);
  end

  // Hang detection: only idle stretches count, real traffic resets it.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("no transaction for %0d cycles, %0d responses outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("FAIL stepper_step_pulse_generator_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Sends one command transaction. Bursts of random length, random gaps
  // in between; valid stays up across back-to-back commands.
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    commands_sent++;
    if (sb.apply_command(c)) active_items++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  // Registers change only with the axis quiet: drop valid, let every
  // response come back, then wait out SETTLE_CYCLES.
  task automatic configure(input logic [HALF_PERIOD_WIDTH-1:0] hp, input logic bm,
                           input logic [RELOAD_WIDTH-1:0] rc);
    logic [CFG_DATA_WIDTH-1:0] noise;
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    noise = 16'($urandom);
    write_reg(REG_HALF_PERIOD, hp);
    // upper bits of the narrow registers carry junk, the block must drop it
    write_reg(REG_BOUNCE_MODE, {noise[15:1], bm});
    write_reg(REG_RELOAD_COUNT, {noise[0], rc});
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t make_cmd(opcode_t op, logic dir, logic signed [15:0] cnt);
    cmd_t c;
    c.opcode       = op;
    c.move_dir     = dir;
    c.toggle_count = cnt;
    return c;
  endfunction

  // Mostly ticks on a moving axis; a stopped axis is usually restarted so
  // the stream keeps reaching the compare/decrement/end-of-move paths.
  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c.move_dir     = 1'($urandom);
    c.toggle_count = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (!sb.running && $urandom_range(0, 2) != 0) pick = 70;
    if (pick < 68) begin
      c.opcode = OP_TICK;
    end else if (pick < 84) begin
      c.opcode = OP_START;
      case ($urandom_range(0, 9))
        0: c.toggle_count = -16'sd1;
        1: c.toggle_count = '0;
        2: ;                                   // full 16-bit random count
        3: c.toggle_count = 16'sd32767;
        default: c.toggle_count = 16'($urandom_range(1, 12));
      endcase
    end else if (pick < 94) begin
      c.opcode = OP_STOP;
    end else begin
      c.opcode = OP_NONE;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main
    cmd_t                         script[$];
    logic [HALF_PERIOD_WIDTH-1:0] hp;
    logic [RELOAD_WIDTH-1:0]      rc;
    int                           target;
    sb = new();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, part one: zero half period (event every tick), plain stop.
    configure(16'd0, 1'b0, '0);
    @(posedge clk);
    write_reg(REG_UNUSED, 16'hFFFF);    // unmapped index must not disturb anything
    cfg_valid <= 1'b0;
    script.push_back(make_cmd(OP_TICK,  1'b0, 16'sd0));       // tick while stopped
    script.push_back(make_cmd(OP_START, 1'b1, 16'sd0));       // zero count acts as stop
    script.push_back(make_cmd(OP_START, 1'b1, 16'sd2));
    repeat (4) script.push_back(make_cmd(OP_TICK, 1'b0, -16'sd1)); // runs out, move_done
    script.push_back(make_cmd(OP_START, 1'b0, -16'sd1));      // run forever
    repeat (2) script.push_back(make_cmd(OP_TICK, 1'b1, 16'sd0));
    script.push_back(make_cmd(OP_NONE,  1'b1, 16'sd5));       // unused opcode
    script.push_back(make_cmd(OP_STOP,  1'b1, 16'sd7));
    script.push_back(make_cmd(OP_START, 1'b1, -16'sd32768));  // other negative: forever
    script.push_back(make_cmd(OP_TICK,  1'b0, 16'sd0));
    script.push_back(make_cmd(OP_START, 1'b0, 16'sd32767));   // restart mid-move
    script.push_back(make_cmd(OP_TICK,  1'b0, 16'sd0));
    script.push_back(make_cmd(OP_STOP,  1'b0, 16'sd0));
    foreach (script[i]) send_cmd(script[i]);

    // Directed, part two: bounce with a reload of one flips dir on every second event.
    configure(16'd1, 1'b1, 15'd1);
    script.delete();
    script.push_back(make_cmd(OP_START, 1'b0, 16'sd1));
    repeat (5) script.push_back(make_cmd(OP_TICK, 1'b0, 16'sd0));
    foreach (script[i]) send_cmd(script[i]);

    // Random phases over a spread of settings, extremes first.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      target = PHASE_ITEMS;
      case (ph)
        0: configure(16'd1, 1'b0, '0);
        1: begin
          configure(16'hFFFF, 1'b1, 15'h7FFF);   // slowest period: no events expected
          target = PHASE_ITEMS / 2;
        end
        2: configure(16'd2, 1'b1, 15'h7FFF);
        3: configure(16'd1, 1'b1, '0);            // bounce with zero reload stops
        4: configure(16'd0, 1'b1, 15'd3);
        default: begin
          hp = 16'($urandom_range(1, 5));
          rc = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 6));
          configure(hp, 1'($urandom), rc);
        end
      endcase
      target += active_items;
      while (active_items < target) send_cmd(random_command());
    end

    // Drain, then watch the idle settle window for anything extra.
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d doing work), %0d responses checked",
             commands_sent, active_items, sb.responses);
    $display("  %0d step toggles, %0d finished moves, %0d register writes",
             sb.step_events, sb.moves_done, reg_writes);
    if (sb.mismatches == 0) begin
      $display("PASS stepper_step_pulse_generator_unit");
    end else begin
      $display("FAIL stepper_step_pulse_generator_unit");
    end
    $finish;
  end

endmodule
